### rtl/core/grid_field_of_view_defines.svh
// assertion macros for the grid field of view block
`ifndef GRID_FIELD_OF_VIEW_DEFINES_SVH
`define GRID_FIELD_OF_VIEW_DEFINES_SVH

// same-cycle implication
`define GFOV_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gfov check failed");

// next-cycle implication
`define GFOV_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gfov check failed");

`endif

### rtl/core/gfov_pkg.sv
// types and constants shared by the grid field of view block
package gfov_pkg;

   localparam int FUNC_W   = 3;
   localparam int COORD_W  = 6;
   localparam int RADIUS_W = 6;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE   = 3'd0,
      FUNC_CAST    = 3'd1,
      FUNC_READ    = 3'd2,
      FUNC_CLR_VIS = 3'd3,
      FUNC_EXPLORE = 3'd4
   } func_type;

   // octant transforms
   localparam logic signed [1:0] OCT_XX [8] =
      '{2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1};
   localparam logic signed [1:0] OCT_XY [8] =
      '{2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0};
   localparam logic signed [1:0] OCT_YX [8] =
      '{2'sd0, 2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd0};
   localparam logic signed [1:0] OCT_YY [8] =
      '{2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1};

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_CLR_ALL,
      OP_CLR_VIS,
      OP_SET_EXP,
      OP_WRITE,
      OP_OCT,
      OP_NEXT_OCT,
      OP_ROW,
      OP_POP,
      OP_LOAD,
      OP_CELL,
      OP_MUL,
      OP_DECIDE,
      OP_READ,
      OP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              sweep_last;
      logic              top_valid;
      logic              dx_done;
      logic              pop_cond;
      logic              stack_empty;
      logic              oct_last;
      logic              off_map;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_WRITE,
      ST_SWEEP_VIS,
      ST_SWEEP_EXP,
      ST_OCT,
      ST_ADV,
      ST_POP,
      ST_MUL,
      ST_DECIDE,
      ST_READ,
      ST_RESP
   } ctrl_state_type;

endpackage

### rtl/core/gfov_req_if.sv
// command channel of the grid field of view block
interface gfov_req_if import gfov_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [COORD_W-1:0]  cell_x;
   logic [COORD_W-1:0]  cell_y;
   logic                blocking;
   logic [RADIUS_W-1:0] view_radius;

   modport source (output valid, func, cell_x, cell_y, blocking, view_radius,
                   input ready);
   modport sink (input valid, func, cell_x, cell_y, blocking, view_radius,
                 output ready);
endinterface

### rtl/core/gfov_rsp_if.sv
// result channel of the grid field of view block
interface gfov_rsp_if;
   logic valid;
   logic ready;
   logic is_visible;
   logic is_explored;
   logic is_blocking;

   modport source (output valid, is_visible, is_explored, is_blocking, input ready);
   modport sink (input valid, is_visible, is_explored, is_blocking, output ready);
endinterface

### rtl/core/gfov_datapath.sv
// maps, scan stack, frame registers and slope arithmetic
module gfov_datapath import gfov_pkg::*; #(
   parameter int MAP_WIDTH  = 64,
   parameter int MAP_HEIGHT = 64,
   parameter int MAX_RADIUS = 63
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [COORD_W-1:0]  req_cell_x,
   input  logic [COORD_W-1:0]  req_cell_y,
   input  logic                req_blocking,
   input  logic [RADIUS_W-1:0] req_view_radius,
   output logic                rsp_is_visible,
   output logic                rsp_is_explored,
   output logic                rsp_is_blocking
);

   localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int DW    = $clog2(MAX_RADIUS + 2) + 1;
   localparam int SW    = $clog2(2 * MAX_RADIUS + 2) + 1;
   localparam int PW    = 2 * SW;
   localparam int QW    = 2 * RW + 1;
   localparam int CW    = $clog2(64 + MAX_RADIUS + 1) + 1;
   localparam int SDW   = $clog2(MAX_RADIUS + 1);
   localparam int SIW   = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;

   typedef struct packed {
      logic [RW-1:0]        row;
      logic signed [DW-1:0] dx;
      logic signed [SW-1:0] sp;
      logic signed [SW-1:0] sq;
      logic signed [SW-1:0] ep;
      logic signed [SW-1:0] eq;
      logic signed [SW-1:0] np;
      logic signed [SW-1:0] nq;
      logic                 blocked;
   } frame_type;

   logic blk_mem [DEPTH];
   logic vis_mem [DEPTH];
   logic exp_mem [DEPTH];
   frame_type stk_mem [MAX_RADIUS];

   logic [FUNC_W-1:0]  func_ff;
   logic [COORD_W-1:0] cx_ff, cy_ff;
   logic               blk_ff;
   logic [RW-1:0]      radius_ff;
   logic [RW-1:0]      radius_in;
   logic [QW-1:0]      rsq_ff;
   logic [2:0]         oct_ff;
   logic [AW-1:0]      sw_ff;
   logic [SDW-1:0]     cnt_ff, cnt_in, cnt_dec;
   logic               top_valid_ff, top_valid_in;
   frame_type          top_ff, top_in, new_frame, stk_rd_ff, stk_wd;
   logic               stk_we;
   logic               off_ff;
   logic [AW-1:0]      addr_ff;
   logic               blk_rd_ff, vis_rd_ff, exp_rd_ff;
   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   logic [QW-1:0]      dist_ff;
   logic               vis_ff, exp_out_ff, blk_out_ff;

   logic               cell_on;
   logic [AW-1:0]      cell_addr;
   logic               sweep_last;
   logic               sweep_op;
   logic signed [DW-1:0] ndx;
   logic signed [CW-1:0] ox, oy, dxv, dyv, xv, yv;
   logic               off_now;
   logic [AW-1:0]      cur_addr;
   logic signed [SW-1:0] lp, lq, rp, rq;
   logic [DW-1:0]      dx_mag;
   logic [RW-1:0]      dxm;
   logic               skip_r, end_l, do_lit;
   logic               blk_we, blk_wd, vis_we, vis_wd, exp_we, exp_wd;
   logic [AW-1:0]      blk_wa, vis_wa, exp_wa, blk_ra;

   function automatic logic signed [CW-1:0] tsel(input logic signed [CW-1:0] v,
                                                 input logic signed [1:0] s);
      logic signed [CW-1:0] r;
      if (s == 2'sd1) begin
         r = v;
      end else if (s == -2'sd1) begin
         r = -v;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   // addressed cell
   assign cell_on   = (int'(cx_ff) < MAP_WIDTH) && (int'(cy_ff) < MAP_HEIGHT);
   assign cell_addr = AW'(cx_ff) + AW'(int'(cy_ff) * MAP_WIDTH);
   assign radius_in = (int'(req_view_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS)
                                                          : RW'(req_view_radius);
   assign sweep_last = (sw_ff == AW'(DEPTH - 1));
   assign sweep_op   = (cmd.op == OP_CLR_ALL) || (cmd.op == OP_CLR_VIS) ||
                       (cmd.op == OP_SET_EXP);
   assign cnt_dec    = cnt_ff - SDW'(1);

   // cell coordinates for the next step
   assign ndx = top_ff.dx + DW'(1);
   assign ox  = CW'(cx_ff);
   assign oy  = CW'(cy_ff);
   assign dxv = CW'(ndx);
   assign dyv = CW'(0) - CW'(top_ff.row);
   assign xv  = ox + tsel(dxv, OCT_XX[oct_ff]) + tsel(dyv, OCT_XY[oct_ff]);
   assign yv  = oy + tsel(dxv, OCT_YX[oct_ff]) + tsel(dyv, OCT_YY[oct_ff]);
   assign off_now = xv[CW-1] || (int'(xv) >= MAP_WIDTH) ||
                    yv[CW-1] || (int'(yv) >= MAP_HEIGHT);
   assign cur_addr = AW'(xv) + AW'(yv * MAP_WIDTH);

   // slopes of the current cell
   assign lp = SW'(1) - (SW'(top_ff.dx) <<< 1);
   assign lq = (SW'(top_ff.row) <<< 1) - SW'(1);
   assign rp = SW'(0) - (SW'(top_ff.dx) <<< 1) - SW'(1);
   assign rq = (SW'(top_ff.row) <<< 1) + SW'(1);
   assign dx_mag = DW'(0) - top_ff.dx;
   assign dxm    = RW'(dx_mag);

   assign skip_r = pa_ff < pb_ff;
   assign end_l  = pc_ff < pd_ff;
   assign do_lit = (cmd.op == OP_DECIDE) && !skip_r && !end_l && (dist_ff < rsq_ff);

   always_comb begin
      new_frame         = top_ff;
      new_frame.row     = top_ff.row + RW'(1);
      new_frame.dx      = DW'(0) - DW'(top_ff.row) - DW'(2);
      new_frame.ep      = lp;
      new_frame.eq      = lq;
      new_frame.np      = '0;
      new_frame.nq      = SW'(1);
      new_frame.blocked = 1'b0;
   end

   always_comb begin
      top_in       = top_ff;
      top_valid_in = top_valid_ff;
      cnt_in       = cnt_ff;
      stk_we       = 1'b0;
      stk_wd       = top_ff;
      case (cmd.op)
         OP_OCT: begin
            top_in.row     = RW'(1);
            top_in.dx      = -DW'(2);
            top_in.sp      = SW'(1);
            top_in.sq      = SW'(1);
            top_in.ep      = '0;
            top_in.eq      = SW'(1);
            top_in.np      = '0;
            top_in.nq      = SW'(1);
            top_in.blocked = 1'b0;
            top_valid_in   = (radius_ff != '0);
            cnt_in         = '0;
         end
         OP_ROW: begin
            top_in.row     = top_ff.row + RW'(1);
            top_in.dx      = DW'(0) - DW'(top_ff.row) - DW'(2);
            top_in.blocked = 1'b0;
         end
         OP_POP: begin
            if (cnt_ff == '0) begin
               top_valid_in = 1'b0;
            end else begin
               cnt_in = cnt_dec;
            end
         end
         OP_LOAD: begin
            top_in = stk_rd_ff;
         end
         OP_CELL: begin
            top_in.dx = ndx;
         end
         OP_DECIDE: begin
            if (!skip_r) begin
               if (end_l) begin
                  top_in.dx = '0;
               end else if (top_ff.blocked) begin
                  if (blk_rd_ff) begin
                     top_in.np = rp;
                     top_in.nq = rq;
                  end else begin
                     top_in.blocked = 1'b0;
                     top_in.sp      = top_ff.np;
                     top_in.sq      = top_ff.nq;
                  end
               end else if (blk_rd_ff && (top_ff.row < radius_ff)) begin
                  top_in.blocked = 1'b1;
                  top_in.np      = rp;
                  top_in.nq      = rq;
                  if (!(pe_ff < pf_ff) && (int'(cnt_ff) < MAX_RADIUS)) begin
                     stk_we = 1'b1;
                     stk_wd = top_in;
                     cnt_in = cnt_ff + SDW'(1);
                     top_in = new_frame;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // map port selection
   always_comb begin
      blk_we = 1'b0;
      blk_wa = sw_ff;
      blk_wd = 1'b0;
      vis_we = 1'b0;
      vis_wa = sw_ff;
      vis_wd = 1'b0;
      exp_we = 1'b0;
      exp_wa = sw_ff;
      exp_wd = 1'b0;
      blk_ra = (cmd.op == OP_CELL) ? cur_addr : cell_addr;
      case (cmd.op)
         OP_CLR_ALL: begin
            blk_we = 1'b1;
            vis_we = 1'b1;
            exp_we = 1'b1;
         end
         OP_CLR_VIS: begin
            vis_we = 1'b1;
         end
         OP_SET_EXP: begin
            exp_we = 1'b1;
            exp_wd = 1'b1;
         end
         OP_WRITE: begin
            blk_we = cell_on;
            blk_wa = cell_addr;
            blk_wd = blk_ff;
         end
         OP_DECIDE: begin
            vis_we = do_lit;
            vis_wa = addr_ff;
            vis_wd = 1'b1;
            exp_we = do_lit;
            exp_wa = addr_ff;
            exp_wd = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_wa] <= blk_wd;
      end
      if ((cmd.op == OP_CELL) || (cmd.op == OP_READ)) begin
         blk_rd_ff <= blk_mem[blk_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_wa] <= vis_wd;
      end
      if (cmd.op == OP_READ) begin
         vis_rd_ff <= vis_mem[cell_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (exp_we) begin
         exp_mem[exp_wa] <= exp_wd;
      end
      if (cmd.op == OP_READ) begin
         exp_rd_ff <= exp_mem[cell_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[cnt_ff[SIW-1:0]] <= stk_wd;
      end
      if ((cmd.op == OP_POP) && (cnt_ff != '0)) begin
         stk_rd_ff <= stk_mem[cnt_dec[SIW-1:0]];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff        <= '0;
         oct_ff       <= '0;
         cnt_ff       <= '0;
         top_valid_ff <= 1'b0;
      end else begin
         if (sweep_op) begin
            sw_ff <= sweep_last ? '0 : sw_ff + AW'(1);
         end
         if (cmd.op == OP_LATCH) begin
            oct_ff <= '0;
         end else if (cmd.op == OP_NEXT_OCT) begin
            oct_ff <= oct_ff + 3'd1;
         end
         cnt_ff       <= cnt_in;
         top_valid_ff <= top_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (cmd.op == OP_LATCH) begin
         func_ff   <= req_func;
         cx_ff     <= req_cell_x;
         cy_ff     <= req_cell_y;
         blk_ff    <= req_blocking;
         radius_ff <= radius_in;
      end
      if (cmd.op == OP_OCT) begin
         rsq_ff <= QW'(radius_ff) * QW'(radius_ff);
      end
      if (cmd.op == OP_CELL) begin
         off_ff  <= off_now;
         addr_ff <= cur_addr;
      end
      if (cmd.op == OP_MUL) begin
         pa_ff   <= top_ff.sp * rq;
         pb_ff   <= rp * top_ff.sq;
         pc_ff   <= lp * top_ff.eq;
         pd_ff   <= top_ff.ep * lq;
         pe_ff   <= top_ff.sp * lq;
         pf_ff   <= lp * top_ff.sq;
         dist_ff <= QW'(dxm) * QW'(dxm) + QW'(top_ff.row) * QW'(top_ff.row);
      end
      if (cmd.op == OP_RESP) begin
         vis_ff     <= cell_on & vis_rd_ff;
         exp_out_ff <= cell_on & exp_rd_ff;
         blk_out_ff <= cell_on & blk_rd_ff;
      end
   end

   assign status.func        = func_ff;
   assign status.sweep_last  = sweep_last;
   assign status.top_valid   = top_valid_ff;
   assign status.dx_done     = !top_ff.dx[DW-1];
   assign status.pop_cond    = top_ff.blocked || (top_ff.row >= radius_ff);
   assign status.stack_empty = (cnt_ff == '0);
   assign status.oct_last    = (oct_ff == 3'd7);
   assign status.off_map     = off_ff;

   assign rsp_is_visible  = vis_ff;
   assign rsp_is_explored = exp_out_ff;
   assign rsp_is_blocking = blk_out_ff;

endmodule

### rtl/core/gfov_ctrl.sv
// command sequencer of the grid field of view block
`include "grid_field_of_view_defines.svh"
module gfov_ctrl import gfov_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (status.func)
               FUNC_WRITE:   state_in = ST_WRITE;
               FUNC_CAST:    state_in = ST_OCT;
               FUNC_CLR_VIS: state_in = ST_SWEEP_VIS;
               FUNC_EXPLORE: state_in = ST_SWEEP_EXP;
               default:      state_in = ST_READ;
            endcase
         end
         ST_WRITE: state_in = ST_READ;
         ST_SWEEP_VIS, ST_SWEEP_EXP: begin
            if (status.sweep_last) state_in = ST_READ;
         end
         ST_OCT: state_in = ST_ADV;
         ST_ADV: begin
            if (!status.top_valid) begin
               state_in = status.oct_last ? ST_READ : ST_OCT;
            end else if (status.dx_done) begin
               if (status.pop_cond && !status.stack_empty) state_in = ST_POP;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_POP: state_in = ST_ADV;
         ST_MUL: state_in = status.off_map ? ST_ADV : ST_DECIDE;
         ST_DECIDE: state_in = ST_ADV;
         ST_READ: state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd.op    = OP_NOP;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.op = OP_CLR_ALL;
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LATCH;
         end
         ST_WRITE:     cmd.op = OP_WRITE;
         ST_SWEEP_VIS: cmd.op = OP_CLR_VIS;
         ST_SWEEP_EXP: cmd.op = OP_SET_EXP;
         ST_OCT:       cmd.op = OP_OCT;
         ST_ADV: begin
            if (!status.top_valid) begin
               cmd.op = OP_NEXT_OCT;
            end else if (status.dx_done) begin
               cmd.op = status.pop_cond ? OP_POP : OP_ROW;
            end else begin
               cmd.op = OP_CELL;
            end
         end
         ST_POP:    cmd.op = OP_LOAD;
         ST_MUL:    cmd.op = OP_MUL;
         ST_DECIDE: cmd.op = OP_DECIDE;
         ST_READ:   cmd.op = OP_READ;
         ST_RESP: begin
            if (out_free) cmd.op = OP_RESP;
         end
         default: cmd.op = OP_NOP;
      endcase
   end

   always_comb begin
      if ((state_ff == ST_RESP) && out_free) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `GFOV_ASSERT_NOW(a_clear_after_reset, $past(reset), state_ff == ST_CLEAR)
   `GFOV_ASSERT_NEXT(a_accept_dispatch, req_valid && req_ready, state_ff == ST_DISPATCH)
   `GFOV_ASSERT_NEXT(a_resp_loaded, (state_ff == ST_RESP) && out_free, rsp_valid_ff)

endmodule

### rtl/core/grid_field_of_view.sv
// top level of the grid field of view block
//
//  channel   dir  handshake            beat contents
//  req_chan  in   valid/ready          func, cell_x, cell_y, blocking, view_radius
//  rsp_chan  out  valid/ready          is_visible, is_explored, is_blocking
//
// one command at a time
// clear visible and explore all sweep the map
// cast: scans the eight octants in turn, with the single frame register and one map read port
// after reset a clearing pass over the whole map runs before req is ready
// a beat waiting on rsp does not hold off the next req beat
module grid_field_of_view import gfov_pkg::*; #(
   parameter int MAP_WIDTH  = 64,
   parameter int MAP_HEIGHT = 64,
   parameter int MAX_RADIUS = 63
) (
   input  logic  clock,
   input  logic  reset,
   gfov_req_if.sink   req_chan,
   gfov_rsp_if.source rsp_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          ready_w;
   logic          valid_w;

   gfov_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready_w),
      .rsp_valid (valid_w),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   gfov_datapath #(
      .MAP_WIDTH  (MAP_WIDTH),
      .MAP_HEIGHT (MAP_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_chan.func),
      .req_cell_x      (req_chan.cell_x),
      .req_cell_y      (req_chan.cell_y),
      .req_blocking    (req_chan.blocking),
      .req_view_radius (req_chan.view_radius),
      .rsp_is_visible  (rsp_chan.is_visible),
      .rsp_is_explored (rsp_chan.is_explored),
      .rsp_is_blocking (rsp_chan.is_blocking)
   );

   assign req_chan.ready = ready_w;
   assign rsp_chan.valid = valid_w;

endmodule
